// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication checked outside reset
`define PCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold at every clock edge outside reset
`define PCC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- src/pcc_pkg.sv -----
// Types and constants of the clamped PID controller.
// No dependencies; used by the core, pcc_regs and pcc_step.
package pcc_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_DELTA = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam int          ADDR_W        = 5;
    localparam logic [2:0]  REG_GAIN_P    = 3'd0;
    localparam logic [2:0]  REG_GAIN_I    = 3'd1;
    localparam logic [2:0]  REG_GAIN_D    = 3'd2;
    localparam logic [2:0]  REG_OUT_LO    = 3'd3;
    localparam logic [2:0]  REG_OUT_HI    = 3'd4;
    localparam logic [2:0]  REG_INTEG_LO  = 3'd5;
    localparam logic [2:0]  REG_INTEG_HI  = 3'd6;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic signed [31:0] out_lower;
        logic signed [31:0] out_upper;
        logic signed [31:0] integ_lower;
        logic signed [31:0] integ_upper;
    } cfg_t;

    typedef struct packed {
        logic        [1:0]  cmd;
        logic signed [15:0] setpoint;
        logic signed [15:0] measured;
        logic signed [16:0] delta_in;
    } item_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clipped_high;
        logic               clipped_low;
    } result_t;

endpackage

// ----- src/pid_controller_clamped_core.sv -----
// Clamped PID controller with anti-windup, fixed point.
//
// Input stream (s_*): one sample per transaction, command in s_tuser, setpoint,
// measured value and optional error delta in s_tdata. Output stream (m_*): the
// limited drive value in m_tdata, clip flags in m_tuser. Gains and limits are
// set through the APB-style port; the user must write them only while the block is idle (not enforced).
//
// Path: an accepted sample is captured in the input register, then the result
// register loads from it and m_tvalid rises with it (input register, then result
// register). Throughput: one sample per cycle while the output is not stalled;
// the integral and previous-error update closes between the input register and
// the result register.
//
// Reset clears the integral, the previous error, both pipeline stages and the
// registers to their defaults (gains 0, limits at full range). If the output
// side stalls, a result waits in the result register and one more sample can
// still be taken into the input register; further samples are then held off.
// Depends on pcc_pkg, pcc_regs, pcc_step.
module pid_controller_clamped_core
#(
    parameter int                 GAIN_FRAC_BITS = 8,
    parameter logic signed [31:0] DERIV_LOWER    = 32'sh8000_0000,
    parameter logic signed [31:0] DERIV_UPPER    = 32'sh7FFF_FFFF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // APB-style configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // sample input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [55:0]                 s_tdata,  // setpoint[15:0], measured[31:16], delta_in[48:32], zero pad
    input  logic [1:0]                  s_tuser,  // cmd
    // result output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,  // drive
    output logic [1:0]                  m_tuser   // clipped_high[0], clipped_low[1]
);

    pcc_pkg::cfg_t    cfg;
    pcc_pkg::item_t   in_reg;
    pcc_pkg::item_t   in_next;
    logic             in_valid_reg;
    pcc_pkg::result_t out_reg;
    pcc_pkg::result_t out_next;
    logic             out_valid_reg;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [16:0] prev_err_reg, prev_err_next;
    logic             advance;
    logic             fire;

    pcc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcc_step
    #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .DERIV_LOWER    (DERIV_LOWER),
        .DERIV_UPPER    (DERIV_UPPER)
    )
    u_step
    (
        .cfg          (cfg),
        .item         (in_reg),
        .integ_cur    (integ_reg),
        .prev_err_cur (prev_err_reg),
        .res          (out_next),
        .integ_new    (integ_next),
        .prev_err_new (prev_err_next)
    );

    // Handshake: result register frees when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    assign in_next.cmd      = s_tuser;
    assign in_next.setpoint = s_tdata[15:0];
    assign in_next.measured = s_tdata[31:16];
    assign in_next.delta_in = s_tdata[48:32];

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
            begin
                integ_reg    <= integ_next;
                prev_err_reg <= prev_err_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= in_next;
        if (fire)
            out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.drive;
    assign m_tuser  = {out_reg.clipped_low, out_reg.clipped_high};

endmodule

// ----- src/pcc_regs.sv -----
// APB-style configuration registers of the PID controller.
// Depends on pcc_pkg (cfg_t, register indexes).
module pcc_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pcc_pkg::cfg_t               cfg
);

    pcc_pkg::cfg_t cfg_reg;
    pcc_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[pcc_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Write decode; indexes past the last register are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                pcc_pkg::REG_GAIN_P:   cfg_next.gain_p      = pwdata[15:0];
                pcc_pkg::REG_GAIN_I:   cfg_next.gain_i      = pwdata[15:0];
                pcc_pkg::REG_GAIN_D:   cfg_next.gain_d      = pwdata[15:0];
                pcc_pkg::REG_OUT_LO:   cfg_next.out_lower   = pwdata;
                pcc_pkg::REG_OUT_HI:   cfg_next.out_upper   = pwdata;
                pcc_pkg::REG_INTEG_LO: cfg_next.integ_lower = pwdata;
                pcc_pkg::REG_INTEG_HI: cfg_next.integ_upper = pwdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p      <= '0;
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.out_lower   <= 32'sh8000_0000;
            cfg_reg.out_upper   <= 32'sh7FFF_FFFF;
            cfg_reg.integ_lower <= 32'sh8000_0000;
            cfg_reg.integ_upper <= 32'sh7FFF_FFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back; gains are returned sign extended
    always_comb
    begin
        case (idx)
            pcc_pkg::REG_GAIN_P:   prdata = {{16{cfg_reg.gain_p[15]}}, cfg_reg.gain_p};
            pcc_pkg::REG_GAIN_I:   prdata = {{16{cfg_reg.gain_i[15]}}, cfg_reg.gain_i};
            pcc_pkg::REG_GAIN_D:   prdata = {{16{cfg_reg.gain_d[15]}}, cfg_reg.gain_d};
            pcc_pkg::REG_OUT_LO:   prdata = cfg_reg.out_lower;
            pcc_pkg::REG_OUT_HI:   prdata = cfg_reg.out_upper;
            pcc_pkg::REG_INTEG_LO: prdata = cfg_reg.integ_lower;
            pcc_pkg::REG_INTEG_HI: prdata = cfg_reg.integ_upper;
            default:               prdata = '0;
        endcase
    end

endmodule

// ----- src/pcc_step.sv -----
// Combinational PID step: terms, saturation, limits and anti-windup.
// Depends on pcc_pkg (cfg_t, item_t, result_t, command codes).
module pcc_step
#(
    parameter int                 GAIN_FRAC_BITS = 8,
    parameter logic signed [31:0] DERIV_LOWER    = 32'sh8000_0000,
    parameter logic signed [31:0] DERIV_UPPER    = 32'sh7FFF_FFFF
)
(
    input  pcc_pkg::cfg_t       cfg,
    input  pcc_pkg::item_t      item,
    input  logic signed [31:0]  integ_cur,
    input  logic signed [16:0]  prev_err_cur,
    output pcc_pkg::result_t    res,
    output logic signed [31:0]  integ_new,
    output logic signed [16:0]  prev_err_new
);

    // Saturate a 34-bit value to signed 32 bit
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic fits;
        fits = (v[33:31] == 3'b000) || (v[33:31] == 3'b111);
        if (fits)
            return v[31:0];
        else if (v[33])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

    // Limit checks upper then lower, so a crossed lower bound wins
    function automatic logic signed [31:0] lim(input logic signed [31:0] v,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
        logic signed [31:0] t;
        t = (hi < v) ? hi : v;
        return (t < lo) ? lo : t;
    endfunction

    logic signed [16:0] err;
    logic signed [17:0] delta;
    logic signed [33:0] prod_p, prod_i, prod_d;
    logic signed [31:0] p_term, i_term, d_term;
    logic signed [32:0] i_sum;
    logic signed [31:0] i_lim;
    logic signed [33:0] total;
    logic signed [33:0] up_ext, lo_ext;
    logic               over, under, gains_zero, is_step;

    assign err   = {item.setpoint[15], item.setpoint} - {item.measured[15], item.measured};
    assign delta = (item.cmd == pcc_pkg::CMD_STEP)
                 ? ({err[16], err} - {prev_err_cur[16], prev_err_cur})
                 : {item.delta_in[16], item.delta_in};

    // Products exact, then floor shift and saturation
    assign prod_p = err * cfg.gain_p;
    assign prod_i = err * cfg.gain_i;
    assign prod_d = delta * cfg.gain_d;
    assign p_term = sat34(prod_p >>> GAIN_FRAC_BITS);
    assign i_term = sat34(prod_i >>> GAIN_FRAC_BITS);
    assign d_term = lim(sat34(prod_d >>> GAIN_FRAC_BITS), DERIV_LOWER, DERIV_UPPER);

    // Integral accumulate, saturate, limit
    assign i_sum = {integ_cur[31], integ_cur} + {i_term[31], i_term};
    assign i_lim = lim(sat34({i_sum[32], i_sum}), cfg.integ_lower, cfg.integ_upper);

    // Output sum and clamp
    assign total  = {{2{p_term[31]}}, p_term} + {{2{i_lim[31]}}, i_lim}
                  + {{2{d_term[31]}}, d_term};
    assign up_ext = {{2{cfg.out_upper[31]}}, cfg.out_upper};
    assign lo_ext = {{2{cfg.out_lower[31]}}, cfg.out_lower};
    assign over   = total > up_ext;
    assign under  = !over && (total < lo_ext);

    assign gains_zero = (cfg.gain_p == '0) && (cfg.gain_i == '0) && (cfg.gain_d == '0);
    assign is_step    = (item.cmd == pcc_pkg::CMD_STEP) || (item.cmd == pcc_pkg::CMD_DELTA);

    always_comb
    begin
        res          = '0;
        integ_new    = integ_cur;
        prev_err_new = prev_err_cur;
        if (item.cmd == pcc_pkg::CMD_CLEAR)
        begin
            integ_new    = '0;
            prev_err_new = '0;
        end
        else if (is_step)
        begin
            if (!gains_zero)
            begin
                integ_new = i_lim;
                if (over)
                begin
                    res.drive        = cfg.out_upper;
                    res.clipped_high = 1'b1;
                    if (i_lim > integ_cur)
                        integ_new = integ_cur;
                end
                else if (under)
                begin
                    res.drive       = cfg.out_lower;
                    res.clipped_low = 1'b1;
                    if (i_lim < integ_cur)
                        integ_new = integ_cur;
                end
                else
                begin
                    res.drive = total[31:0];
                end
            end
            if (item.cmd == pcc_pkg::CMD_STEP)
                prev_err_new = err;
        end
    end

endmodule

// ----- src/pcc_checker.sv -----
// Port-level checker for the PID controller core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pcc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Output cannot be clipped both ways at once
    `PCC_ASSERT_ALWAYS(a_clip_excl, clk, rst_n, !(m_tvalid && m_tuser[0] && m_tuser[1]), "both clip flags set")

    // Empty result register never holds off input
    `PCC_ASSERT(a_ready_when_empty, clk, rst_n, !m_tvalid |-> s_tready, "input stalled with empty output")

    // Accepted sample reaches the output through the result register when not stalled
    `PCC_ASSERT(a_latency, clk, rst_n, (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid, "result missing after accepted sample")

    // Stalled result holds
    `PCC_ASSERT(a_hold, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind pid_controller_clamped_core pcc_checker u_pcc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
